// ----- sv/pppb_pkg.sv -----
// Shared types and constants for the ping-pong playback buffer controller.
package pppb_pkg;

  // Divider widths: dividend is clock plus half the rate, divisor is the rate
  localparam int unsigned DIV_W = 33;
  localparam int unsigned DVS_W = 32;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  // Reload range: ticks must lie in 1 .. 2^RLD_W
  localparam int unsigned RLD_W = 16;

  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_SET_RATE  = 4'd1,
    OP_ACQUIRE   = 4'd2,
    OP_COMMIT    = 4'd3,
    OP_START     = 4'd4,
    OP_STOP      = 4'd5,
    OP_HALF_DONE = 4'd6,
    OP_FULL_DONE = 4'd7,
    OP_DMA_ERR   = 4'd8,
    OP_DMA_UNDER = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    HS_FREE    = 2'd0,
    HS_FILLING = 2'd1,
    HS_READY   = 2'd2,
    HS_PLAYING = 2'd3
  } hs_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_BUSY = 2'd2
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } fsm_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [1:0]  half_select;
    logic [31:0] req_rate;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        half_index;
    logic [15:0] timer_period;
    logic        running;
    logic [1:0]  half0_state;
    logic [1:0]  half1_state;
    logic [31:0] half_events;
    logic [31:0] full_events;
    logic [31:0] error_events;
    logic [31:0] underrun_events;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/ping_pong_playback_buffer_control_unit.sv -----
// Top level: ping-pong playback buffer sequencer, state and counters.
// One item at a time: an accepted item is latched and executed, and its result is written
// to the output register once that register is free. A set_rate that reaches the divide
// first runs the one-bit-per-cycle divider (33 steps for the 33-bit dividend), then writes
// its result the same way. in_ready is high whenever no item is in progress, even while an
// earlier result waits to be taken.
module ping_pong_playback_buffer_control_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  pppb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pppb_pkg::out_item_t out_data
);

  pppb_pkg::fsm_t      fsm_r, fsm_nxt;
  pppb_pkg::in_item_t  item_r, item_nxt;
  pppb_pkg::hs_t       h0_r, h0_nxt, h1_r, h1_nxt;
  logic                run_r, run_nxt;
  logic                init_r, init_nxt;
  logic [15:0]         reload_r, reload_nxt;
  logic [31:0]         hcnt_r, hcnt_nxt, fcnt_r, fcnt_nxt;
  logic [31:0]         ecnt_r, ecnt_nxt, ucnt_r, ucnt_nxt;
  logic [31:0]         clk_hz_r;
  logic                out_valid_r, out_valid_nxt;
  pppb_pkg::out_item_t out_data_r, out_data_nxt;

  pppb_pkg::div_req_t  div_req;
  pppb_pkg::div_rsp_t  div_rsp;
  logic                div_start;

  pppb_pkg::st_t       status;
  logic                granted;
  logic                wr_out;
  logic                out_free;
  logic                rate_ok;
  logic [1:0]          under;
  logic [pppb_pkg::DIV_W-1:0] q;
  logic                q_bad;

  pppb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Rounded divide operands: (clock + rate/2) / rate
  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = {1'b0, clk_hz_r} + {2'b00, item_r.req_rate[31:1]};
    div_req.divisor  = item_r.req_rate;
  end

  // Check the quotient against the 1 .. 65536 tick range
  always_comb begin
    q     = div_rsp.quotient;
    q_bad = (q == '0) || (q[pppb_pkg::DIV_W-1:pppb_pkg::RLD_W+1] != '0) ||
            (q[pppb_pkg::RLD_W] && (q[pppb_pkg::RLD_W-1:0] != '0));
  end

  assign rate_ok  = init_r && (clk_hz_r != '0) && (item_r.req_rate != '0) && !run_r;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (fsm_r == pppb_pkg::S_IDLE);

  // Sequence the item and apply its operation
  always_comb begin
    fsm_nxt       = fsm_r;
    item_nxt      = item_r;
    h0_nxt        = h0_r;
    h1_nxt        = h1_r;
    run_nxt       = run_r;
    init_nxt      = init_r;
    reload_nxt    = reload_r;
    hcnt_nxt      = hcnt_r;
    fcnt_nxt      = fcnt_r;
    ecnt_nxt      = ecnt_r;
    ucnt_nxt      = ucnt_r;
    status        = pppb_pkg::ST_OK;
    granted       = 1'b0;
    wr_out        = 1'b0;
    under         = 2'd0;
    div_start     = 1'b0;

    case (fsm_r)
      pppb_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          fsm_nxt  = pppb_pkg::S_EXEC;
        end
      end

      pppb_pkg::S_EXEC: begin
        if ((pppb_pkg::op_t'(item_r.operation) == pppb_pkg::OP_SET_RATE) && rate_ok) begin
          div_start = 1'b1;
          fsm_nxt   = pppb_pkg::S_DIV;
        end else if (out_free) begin
          wr_out  = 1'b1;
          fsm_nxt = pppb_pkg::S_IDLE;
          case (pppb_pkg::op_t'(item_r.operation))
            pppb_pkg::OP_INIT: begin
              if (run_r) begin
                status = pppb_pkg::ST_BUSY;
              end else begin
                h0_nxt   = pppb_pkg::HS_FREE;
                h1_nxt   = pppb_pkg::HS_FREE;
                hcnt_nxt = '0;
                fcnt_nxt = '0;
                ecnt_nxt = '0;
                ucnt_nxt = '0;
                init_nxt = 1'b1;
              end
            end
            pppb_pkg::OP_SET_RATE: begin
              // Divide-free outcomes only; the divide path left above
              if (!init_r || clk_hz_r == '0 || item_r.req_rate == '0) begin
                status = pppb_pkg::ST_ERR;
              end else begin
                status = pppb_pkg::ST_BUSY;
              end
            end
            pppb_pkg::OP_ACQUIRE: begin
              if (!init_r) begin
                status = pppb_pkg::ST_ERR;
              end else if (h0_r == pppb_pkg::HS_FREE) begin
                h0_nxt = pppb_pkg::HS_FILLING;
              end else if (h1_r == pppb_pkg::HS_FREE) begin
                h1_nxt  = pppb_pkg::HS_FILLING;
                granted = 1'b1;
              end else begin
                status = pppb_pkg::ST_ERR;
              end
            end
            pppb_pkg::OP_COMMIT: begin
              if (item_r.half_select[1]) begin
                status = pppb_pkg::ST_ERR;
              end else if (!item_r.half_select[0]) begin
                if (h0_r != pppb_pkg::HS_FILLING) status = pppb_pkg::ST_ERR;
                else h0_nxt = pppb_pkg::HS_READY;
              end else begin
                if (h1_r != pppb_pkg::HS_FILLING) status = pppb_pkg::ST_ERR;
                else h1_nxt = pppb_pkg::HS_READY;
              end
            end
            pppb_pkg::OP_START: begin
              if (!init_r || h0_r != pppb_pkg::HS_READY || h1_r != pppb_pkg::HS_READY) begin
                status = pppb_pkg::ST_ERR;
              end else if (run_r) begin
                status = pppb_pkg::ST_BUSY;
              end else begin
                h0_nxt  = pppb_pkg::HS_PLAYING;
                run_nxt = 1'b1;
              end
            end
            pppb_pkg::OP_STOP: begin
              if (!init_r) status = pppb_pkg::ST_ERR;
              else run_nxt = 1'b0;
            end
            pppb_pkg::OP_HALF_DONE: begin
              // Free half 0, play half 1, count each half out of step
              if (run_r) begin
                hcnt_nxt = hcnt_r + 32'd1;
                under    = {1'b0, h0_r != pppb_pkg::HS_PLAYING} +
                           {1'b0, h1_r != pppb_pkg::HS_READY};
                h0_nxt   = pppb_pkg::HS_FREE;
                h1_nxt   = pppb_pkg::HS_PLAYING;
                ucnt_nxt = ucnt_r + {30'd0, under};
              end
            end
            pppb_pkg::OP_FULL_DONE: begin
              // Free half 1, play half 0
              if (run_r) begin
                fcnt_nxt = fcnt_r + 32'd1;
                under    = {1'b0, h1_r != pppb_pkg::HS_PLAYING} +
                           {1'b0, h0_r != pppb_pkg::HS_READY};
                h1_nxt   = pppb_pkg::HS_FREE;
                h0_nxt   = pppb_pkg::HS_PLAYING;
                ucnt_nxt = ucnt_r + {30'd0, under};
              end
            end
            pppb_pkg::OP_DMA_ERR: begin
              if (init_r) ecnt_nxt = ecnt_r + 32'd1;
            end
            pppb_pkg::OP_DMA_UNDER: begin
              if (init_r) ucnt_nxt = ucnt_r + 32'd1;
            end
            default: begin
              status = pppb_pkg::ST_ERR;
            end
          endcase
        end
      end

      pppb_pkg::S_DIV: begin
        if (div_rsp.done) fsm_nxt = pppb_pkg::S_FIN;
      end

      pppb_pkg::S_FIN: begin
        // Take the reload value if the tick count is in range
        if (out_free) begin
          wr_out  = 1'b1;
          fsm_nxt = pppb_pkg::S_IDLE;
          if (q_bad) status = pppb_pkg::ST_ERR;
          else reload_nxt = q[pppb_pkg::RLD_W-1:0] - 16'd1;
        end
      end

      default: begin
        fsm_nxt = pppb_pkg::S_IDLE;
      end
    endcase
  end

  // Load the result register from the updated state
  always_comb begin
    out_data_nxt                 = out_data_r;
    out_valid_nxt                = out_ready ? 1'b0 : out_valid_r;
    if (wr_out) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.status          = status;
      out_data_nxt.half_index      = granted;
      out_data_nxt.timer_period    = reload_nxt;
      out_data_nxt.running         = run_nxt;
      out_data_nxt.half0_state     = h0_nxt;
      out_data_nxt.half1_state     = h1_nxt;
      out_data_nxt.half_events     = hcnt_nxt;
      out_data_nxt.full_events     = fcnt_nxt;
      out_data_nxt.error_events    = ecnt_nxt;
      out_data_nxt.underrun_events = ucnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= pppb_pkg::S_IDLE;
      h0_r        <= pppb_pkg::HS_FREE;
      h1_r        <= pppb_pkg::HS_FREE;
      run_r       <= 1'b0;
      init_r      <= 1'b0;
      reload_r    <= '0;
      hcnt_r      <= '0;
      fcnt_r      <= '0;
      ecnt_r      <= '0;
      ucnt_r      <= '0;
      clk_hz_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      h0_r        <= h0_nxt;
      h1_r        <= h1_nxt;
      run_r       <= run_nxt;
      init_r      <= init_nxt;
      reload_r    <= reload_nxt;
      hcnt_r      <= hcnt_nxt;
      fcnt_r      <= fcnt_nxt;
      ecnt_r      <= ecnt_nxt;
      ucnt_r      <= ucnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) clk_hz_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divider completion only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (fsm_r == pppb_pkg::S_DIV))
    else $error("divider finished outside the divide state");

  // An accepted item closes the input until it has been executed
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (fsm_r == pppb_pkg::S_EXEC) && !in_ready)
    else $error("accepted item not latched for execution");

  // While running, one half is always playing
  a_run_playing: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (h0_r == pppb_pkg::HS_PLAYING || h1_r == pppb_pkg::HS_PLAYING))
    else $error("running with no half playing");

  // The reload value changes only when a divide result is taken
  a_reload_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(reload_r)) |-> ($past(fsm_r) == pppb_pkg::S_FIN))
    else $error("reload value changed outside divide completion");

endmodule

// ----- sv/pppb_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module pppb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pppb_pkg::div_req_t  req,
  output pppb_pkg::div_rsp_t  rsp
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [pppb_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [pppb_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [pppb_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [pppb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [pppb_pkg::DIV_W:0]   shifted;
  logic [pppb_pkg::DIV_W:0]   diff;
  logic                       fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    shifted = {rem_r, quo_r[pppb_pkg::DIV_W-1]};
    diff    = shifted - {{(pppb_pkg::DIV_W+1-pppb_pkg::DVS_W){1'b0}}, dvs_r};
    fits    = ~diff[pppb_pkg::DIV_W];
  end

  // Sequence the steps
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = pppb_pkg::CNT_W'(pppb_pkg::DIV_W - 1);
    end else if (busy_r) begin
      rem_nxt = fits ? diff[pppb_pkg::DIV_W-1:0] : shifted[pppb_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[pppb_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A new division must not be started over one in progress
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule
